/* rtl/rbrm_pkg.sv */
// Shared types, codes and helper functions for the ring buffer region manager.
// Used by ring_buffer_region_manager; depends on nothing else.

package rbrm_pkg;

  // Size of the addressable buffer in bytes.
  localparam int BUF_BYTES = 65536;
  localparam int BUF_LIM_INT = (BUF_BYTES > 131071) ? 131071 : BUF_BYTES;
  localparam logic [16:0] BUF_LIM = 17'(BUF_LIM_INT);

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 120;

  localparam logic [15:0] RST_START_POS = 16'd4096;
  localparam logic [16:0] RST_END_POS = 17'd65536;
  localparam logic [16:0] RST_MAX_READ = 17'd4096;

  localparam logic [16:0] MAX17 = 17'h1FFFF;

  // Configuration register indexes.
  localparam logic [1:0] REG_START_POS = 2'd0;
  localparam logic [1:0] REG_END_POS = 2'd1;
  localparam logic [1:0] REG_MAX_READ = 2'd2;

  // Command codes.
  localparam logic [2:0] FN_RESERVE_ANY = 3'd0;
  localparam logic [2:0] FN_RESERVE_N = 3'd1;
  localparam logic [2:0] FN_COMMIT = 3'd2;
  localparam logic [2:0] FN_PEEK = 3'd3;
  localparam logic [2:0] FN_READ = 3'd4;
  localparam logic [2:0] FN_RELEASE = 3'd5;
  localparam logic [2:0] FN_WRITE = 3'd6;

  // Result status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_OFFSET = 2'd2;
  localparam logic [1:0] ST_TOO_LARGE = 2'd3;

  typedef logic signed [19:0] sval_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] region_offset;
    logic [16:0] region_len;
    logic        copy_valid;
    logic        copy_from_input;
    logic [15:0] copy_src;
    logic [15:0] copy_dst;
    logic [16:0] copy_len;
    logic [16:0] bytes_readable;
    logic [16:0] bytes_writable;
    logic        last;
  } result_t;

  function automatic sval_t to_s(logic [16:0] v);
    return $signed({3'b000, v});
  endfunction

  function automatic logic [16:0] clamp17(sval_t v);
    logic [16:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > to_s(MAX17)) begin
      r = MAX17;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] off16(sval_t v);
    logic [16:0] c;
    c = clamp17(v);
    return c[15:0];
  endfunction

  function automatic logic [16:0] readable_cnt(sval_t rp, sval_t wp, sval_t de,
                                               logic empty, sval_t s);
    logic [16:0] r;
    if (wp > rp) begin
      r = clamp17(wp - rp);
    end else if (wp == rp && empty) begin
      r = '0;
    end else begin
      r = clamp17((wp - s) + (de - rp));
    end
    return r;
  endfunction

  function automatic logic [16:0] writable_cnt(sval_t rp, sval_t wp, logic empty,
                                               sval_t s, sval_t e);
    logic [16:0] r;
    if (wp < rp) begin
      r = clamp17(rp - wp);
    end else if (wp == rp) begin
      r = empty ? clamp17(e - s) : '0;
    end else begin
      r = clamp17((rp - s) + (e - wp));
    end
    return r;
  endfunction

endpackage

/* rtl/ring_buffer_region_manager.sv */
// Ring buffer region manager: pointer state, command decode and result queue.
// Depends on rbrm_pkg for codes, the result type and pointer arithmetic helpers.

// Each command goes into an input register and is worked out into an output register
// once the output register is free and no second result is held, so one command is
// taken per cycle unless the output is stalled or a second result is held. A write that
// wraps the data end with bytes on both sides gives two results; the second waits in a
// holding register and no command moves on while it does. Writes to start_pos or end_pos
// reset the pointers and mark the ring empty.

module ring_buffer_region_manager (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // count [16:0], commit_offset [32:17], zero padding [39:33]
  input  logic [rbrm_pkg::S_TDATA_W-1:0]  s_tdata,
  // func [2:0]
  input  logic [2:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // region_offset [15:0], region_len [32:16], copy_valid [33], copy_from_input [34],
  // copy_src [50:35], copy_dst [66:51], copy_len [83:67], bytes_readable [100:84],
  // bytes_writable [117:101], zero padding [119:118]
  output logic [rbrm_pkg::M_TDATA_W-1:0]  m_tdata,
  // status [1:0]
  output logic [1:0]                      m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [16:0]                     cfg_data
);

  logic [15:0] start_pos;
  logic [16:0] end_pos;
  logic [16:0] max_read;
  logic [16:0] act_start;
  logic [16:0] act_end;

  logic [15:0] start_pos_next;
  logic [16:0] end_pos_next;
  logic [16:0] max_read_next;
  logic [16:0] act_start_next;
  logic [16:0] act_end_next;
  logic [16:0] end_lim;
  logic        cfg_wr;
  logic        reinit;

  logic [16:0] read_pos;
  logic [16:0] write_pos;
  logic [16:0] data_end;
  logic        is_empty;

  logic [16:0] read_pos_next;
  logic [16:0] write_pos_next;
  logic [16:0] data_end_next;
  logic        is_empty_next;

  logic        inq_valid;
  logic [2:0]  inq_func;
  logic [16:0] inq_count;
  logic [15:0] inq_coff;

  logic        out_valid;
  rbrm_pkg::result_t out_q;
  logic        pend_valid;
  rbrm_pkg::result_t pend_q;

  rbrm_pkg::result_t res0;
  rbrm_pkg::result_t res1;
  logic        two;
  logic        go;
  logic        s_acc;

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid & cfg_ready;
  assign s_acc = s_tvalid & s_tready;
  assign go = inq_valid & ~pend_valid & (~out_valid | m_tready);
  assign s_tready = ~inq_valid | go;

  always_comb begin
    start_pos_next = start_pos;
    end_pos_next = end_pos;
    max_read_next = max_read;
    reinit = 1'b0;
    if (rst) begin
      start_pos_next = rbrm_pkg::RST_START_POS;
      end_pos_next = rbrm_pkg::RST_END_POS;
      max_read_next = rbrm_pkg::RST_MAX_READ;
      reinit = 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        rbrm_pkg::REG_START_POS: begin
          start_pos_next = cfg_data[15:0];
          reinit = 1'b1;
        end
        rbrm_pkg::REG_END_POS: begin
          end_pos_next = cfg_data;
          reinit = 1'b1;
        end
        rbrm_pkg::REG_MAX_READ: begin
          max_read_next = cfg_data;
        end
        default: begin
        end
      endcase
    end
    act_start_next = ({1'b0, start_pos_next} > rbrm_pkg::BUF_LIM) ?
                     rbrm_pkg::BUF_LIM : {1'b0, start_pos_next};
    end_lim = (end_pos_next > rbrm_pkg::BUF_LIM) ? rbrm_pkg::BUF_LIM : end_pos_next;
    act_end_next = (end_lim < act_start_next) ? act_start_next : end_lim;
  end

  always_comb begin
    rbrm_pkg::sval_t rp;
    rbrm_pkg::sval_t wp;
    rbrm_pkg::sval_t de;
    rbrm_pkg::sval_t s;
    rbrm_pkg::sval_t e;
    rbrm_pkg::sval_t n;
    rbrm_pkg::sval_t coff;
    rbrm_pkg::sval_t t;
    rbrm_pkg::sval_t first;
    rbrm_pkg::sval_t second;
    rbrm_pkg::sval_t tail;
    logic [16:0] rd_cur;
    logic [16:0] wr_cur;
    logic [16:0] c;
    logic        do_fetch;

    rp = rbrm_pkg::to_s(read_pos);
    wp = rbrm_pkg::to_s(write_pos);
    de = rbrm_pkg::to_s(data_end);
    s = rbrm_pkg::to_s(act_start);
    e = rbrm_pkg::to_s(act_end);
    n = rbrm_pkg::to_s(inq_count);
    coff = rbrm_pkg::to_s({1'b0, inq_coff});
    rd_cur = rbrm_pkg::readable_cnt(rp, wp, de, is_empty, s);
    wr_cur = rbrm_pkg::writable_cnt(rp, wp, is_empty, s, e);
    t = '0;
    first = '0;
    second = '0;
    tail = '0;
    c = '0;
    do_fetch = 1'b0;

    read_pos_next = read_pos;
    write_pos_next = write_pos;
    data_end_next = data_end;
    is_empty_next = is_empty;
    res0 = '0;
    res0.last = 1'b1;
    res1 = '0;
    res1.last = 1'b1;
    two = 1'b0;

    unique case (inq_func)
      rbrm_pkg::FN_RESERVE_ANY: begin
        if (wp < rp) begin
          res0.region_offset = rbrm_pkg::off16(wp);
          res0.region_len = rbrm_pkg::clamp17(rp - wp);
        end else if (wp == rp && !is_empty) begin
          res0.status = rbrm_pkg::ST_NO_SPACE;
        end else begin
          data_end_next = act_end;
          res0.region_offset = rbrm_pkg::off16(wp);
          res0.region_len = rbrm_pkg::clamp17(e - wp);
        end
      end
      rbrm_pkg::FN_RESERVE_N: begin
        if (wp < rp) begin
          if (rp - wp < n) begin
            res0.status = rbrm_pkg::ST_NO_SPACE;
          end else begin
            res0.region_offset = rbrm_pkg::off16(wp);
            res0.region_len = inq_count;
          end
        end else if (wp == rp && !is_empty) begin
          res0.status = rbrm_pkg::ST_NO_SPACE;
        end else if (e - wp >= n) begin
          res0.region_offset = rbrm_pkg::off16(wp);
          res0.region_len = inq_count;
        end else if (rp - s >= n) begin
          data_end_next = write_pos;
          write_pos_next = act_start;
          res0.region_offset = rbrm_pkg::off16(s);
          res0.region_len = inq_count;
        end else begin
          res0.status = rbrm_pkg::ST_NO_SPACE;
        end
      end
      rbrm_pkg::FN_COMMIT: begin
        if (coff < s || coff >= e) begin
          res0.status = rbrm_pkg::ST_BAD_OFFSET;
        end else begin
          t = wp + n;
          if (t > e) begin
            t = e;
          end
          if (t >= e && rp > s) begin
            t = s;
          end
          write_pos_next = t[16:0];
          if (inq_count != '0) begin
            is_empty_next = 1'b0;
          end
        end
      end
      rbrm_pkg::FN_PEEK: begin
        if (inq_count > rd_cur) begin
          res0.status = rbrm_pkg::ST_NO_SPACE;
        end else begin
          do_fetch = 1'b1;
        end
      end
      rbrm_pkg::FN_READ: begin
        if (inq_count > max_read) begin
          res0.status = rbrm_pkg::ST_TOO_LARGE;
        end else if (inq_count > rd_cur) begin
          res0.status = rbrm_pkg::ST_NO_SPACE;
        end else begin
          do_fetch = 1'b1;
        end
      end
      rbrm_pkg::FN_RELEASE: begin
        c = (inq_count < rd_cur) ? inq_count : rd_cur;
        if (c != '0) begin
          read_pos_next = rbrm_pkg::clamp17(rp + rbrm_pkg::to_s(c));
          is_empty_next = (read_pos_next == write_pos);
        end
      end
      rbrm_pkg::FN_WRITE: begin
        if (wr_cur < inq_count) begin
          res0.status = rbrm_pkg::ST_NO_SPACE;
        end else begin
          if (inq_count != '0) begin
            is_empty_next = 1'b0;
          end
          res0.region_offset = rbrm_pkg::off16(wp);
          res0.region_len = inq_count;
          if (wp + n >= e) begin
            first = e - wp;
            if (first < 0) begin
              first = '0;
            end
            if (first > n) begin
              first = n;
            end
            second = n - first;
            data_end_next = act_end;
            write_pos_next = rbrm_pkg::clamp17(s + second);
            res1 = res0;
            if (first > 0) begin
              res0.copy_valid = 1'b1;
              res0.copy_from_input = 1'b1;
              res0.copy_dst = rbrm_pkg::off16(wp);
              res0.copy_len = rbrm_pkg::clamp17(first);
              res0.last = (second <= 0);
              if (second > 0) begin
                two = 1'b1;
                res1.copy_valid = 1'b1;
                res1.copy_from_input = 1'b1;
                res1.copy_src = rbrm_pkg::off16(first);
                res1.copy_dst = rbrm_pkg::off16(s);
                res1.copy_len = rbrm_pkg::clamp17(second);
                res1.last = 1'b1;
              end
            end else if (second > 0) begin
              res0.copy_valid = 1'b1;
              res0.copy_from_input = 1'b1;
              res0.copy_src = rbrm_pkg::off16(first);
              res0.copy_dst = rbrm_pkg::off16(s);
              res0.copy_len = rbrm_pkg::clamp17(second);
            end
          end else begin
            write_pos_next = rbrm_pkg::clamp17(wp + n);
            if (inq_count != '0) begin
              res0.copy_valid = 1'b1;
              res0.copy_from_input = 1'b1;
              res0.copy_dst = rbrm_pkg::off16(wp);
              res0.copy_len = inq_count;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (do_fetch) begin
      if (rp + n >= de) begin
        tail = de - rp;
        if (tail < 0) begin
          tail = '0;
        end
        if (tail > s) begin
          res0.status = rbrm_pkg::ST_NO_SPACE;
        end else begin
          t = s - tail;
          read_pos_next = t[16:0];
          data_end_next = act_end;
          res0.region_offset = rbrm_pkg::off16(t);
          res0.region_len = inq_count;
          if (tail > 0) begin
            res0.copy_valid = 1'b1;
            res0.copy_src = rbrm_pkg::off16(rp);
            res0.copy_dst = rbrm_pkg::off16(t);
            res0.copy_len = rbrm_pkg::clamp17(tail);
          end
        end
      end else begin
        res0.region_offset = rbrm_pkg::off16(rp);
        res0.region_len = inq_count;
      end
    end

    res0.bytes_readable = rbrm_pkg::readable_cnt(rbrm_pkg::to_s(read_pos_next),
        rbrm_pkg::to_s(write_pos_next), rbrm_pkg::to_s(data_end_next), is_empty_next, s);
    res0.bytes_writable = rbrm_pkg::writable_cnt(rbrm_pkg::to_s(read_pos_next),
        rbrm_pkg::to_s(write_pos_next), is_empty_next, s, e);
    res1.bytes_readable = res0.bytes_readable;
    res1.bytes_writable = res0.bytes_writable;
  end

  always_ff @(posedge clk) begin
    start_pos <= start_pos_next;
    end_pos <= end_pos_next;
    max_read <= max_read_next;
    act_start <= act_start_next;
    act_end <= act_end_next;
    if (reinit) begin
      read_pos <= act_start_next;
      write_pos <= act_start_next;
      data_end <= act_end_next;
      is_empty <= 1'b1;
    end else if (go) begin
      read_pos <= read_pos_next;
      write_pos <= write_pos_next;
      data_end <= data_end_next;
      is_empty <= is_empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (s_acc) begin
        inq_valid <= 1'b1;
      end else if (go) begin
        inq_valid <= 1'b0;
      end
      if (go) begin
        out_valid <= 1'b1;
        pend_valid <= two;
      end else if (out_valid && m_tready) begin
        if (pend_valid) begin
          pend_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      inq_func <= s_tuser;
      inq_count <= s_tdata[16:0];
      inq_coff <= s_tdata[32:17];
    end
    if (go) begin
      out_q <= res0;
      pend_q <= res1;
    end else if (out_valid && m_tready && pend_valid) begin
      out_q <= pend_q;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser = out_q.status;
  assign m_tlast = out_q.last;
  assign m_tdata = {2'b00, out_q.bytes_writable, out_q.bytes_readable, out_q.copy_len,
                    out_q.copy_dst, out_q.copy_src, out_q.copy_from_input,
                    out_q.copy_valid, out_q.region_len, out_q.region_offset};

  a_pend_behind_first: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid && !out_q.last)
    else $error("second result held without an unfinished first result");

  a_refused_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.status != rbrm_pkg::ST_OK |->
      out_q.region_len == '0 && !out_q.copy_valid)
    else $error("refused transaction carries a region or copy");

  a_copy_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.copy_valid |-> out_q.copy_len != '0)
    else $error("copy descriptor with zero length");

  a_cfg_reinit: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready &&
      (cfg_index == rbrm_pkg::REG_START_POS || cfg_index == rbrm_pkg::REG_END_POS)
      |=> is_empty && read_pos == write_pos && read_pos == act_start)
    else $error("pointers not reset after ring bounds write");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Testbench for ring_buffer_region_manager: a directed command table, then random command
// phases under changing ring settings, each result checked against a predicted or pinned
// value. Depends on rbrm_pkg and the ring_buffer_region_manager RTL.

module tb;

  localparam logic [2:0] FN_UNKNOWN = 3'd7;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int ITEMS = 1900;
  localparam int QUIET_TAIL = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam longint BUF = rbrm_pkg::BUF_BYTES;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [rbrm_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [2:0]                     s_tuser = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [rbrm_pkg::M_TDATA_W-1:0] m_tdata;
  logic [1:0]                     m_tuser;
  logic                           m_tlast;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [1:0]                     cfg_index = '0;
  logic [16:0]                    cfg_data = '0;

  ring_buffer_region_manager uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  longint  cfg_start;
  longint  cfg_end;
  longint  cfg_max_read;
  longint  rd_ptr;
  longint  wr_ptr;
  longint  data_mark;
  bit      ring_empty;
  rbrm_pkg::result_t region_results[$];

  int err_count = 0;
  int sent = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b0;
  bit stall_en = 1'b0;
  bit hold_req = 1'b0;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [16:0] val;
    logic [2:0]  fn;
    logic [16:0] cnt;
    logic [15:0] off;
    bit          pinned;
    rbrm_pkg::result_t fixed;
  } step_row_t;

  step_row_t steps[$];

  function automatic longint sat17(longint v);
    if (v < 0) return 0;
    if (v > 131071) return 131071;
    return v;
  endfunction

  function automatic longint ring_lo();
    return (cfg_start > BUF) ? BUF : cfg_start;
  endfunction

  function automatic longint ring_hi();
    longint e;
    e = (cfg_end > BUF) ? BUF : cfg_end;
    if (e < ring_lo()) e = ring_lo();
    return e;
  endfunction

  function automatic void reset_pointers();
    rd_ptr = sat17(ring_lo());
    wr_ptr = rd_ptr;
    data_mark = sat17(ring_hi());
    ring_empty = 1'b1;
  endfunction

  function automatic longint fill_bytes();
    if (wr_ptr > rd_ptr) return sat17(wr_ptr - rd_ptr);
    if (wr_ptr == rd_ptr && ring_empty) return 0;
    return sat17((wr_ptr - ring_lo()) + (data_mark - rd_ptr));
  endfunction

  function automatic longint room_bytes();
    if (wr_ptr < rd_ptr) return sat17(rd_ptr - wr_ptr);
    if (wr_ptr == rd_ptr) return ring_empty ? sat17(ring_hi() - ring_lo()) : 0;
    return sat17((rd_ptr - ring_lo()) + (ring_hi() - wr_ptr));
  endfunction

  function automatic void queue_result(logic [1:0] st, longint roff, longint rlen, bit cv,
                                       bit cfi, longint csrc, longint cdst, longint clen,
                                       bit lst);
    rbrm_pkg::result_t r;
    longint  t;
    r.status = st;
    t = sat17(roff);
    r.region_offset = t[15:0];
    r.region_len = 17'(sat17(rlen));
    r.copy_valid = cv;
    r.copy_from_input = cfi;
    t = sat17(csrc);
    r.copy_src = t[15:0];
    t = sat17(cdst);
    r.copy_dst = t[15:0];
    r.copy_len = 17'(sat17(clen));
    r.bytes_readable = 17'(fill_bytes());
    r.bytes_writable = 17'(room_bytes());
    r.last = lst;
    region_results.push_back(r);
  endfunction

  // Peek or read once the size checks pass; a tail that crosses the data end is
  // copied below the ring start so the region comes out contiguous.
  function automatic void linear_fetch(longint n);
    longint s;
    longint tail;
    longint old;
    s = ring_lo();
    if (rd_ptr + n >= data_mark) begin
      tail = data_mark - rd_ptr;
      old = rd_ptr;
      if (tail < 0) tail = 0;
      if (tail > s) begin
        queue_result(rbrm_pkg::ST_NO_SPACE, 0, 0, 0, 0, 0, 0, 0, 1);
      end else begin
        rd_ptr = s - tail;
        data_mark = sat17(ring_hi());
        if (tail > 0) queue_result(rbrm_pkg::ST_OK, rd_ptr, n, 1, 0, old, rd_ptr, tail, 1);
        else queue_result(rbrm_pkg::ST_OK, rd_ptr, n, 0, 0, 0, 0, 0, 1);
      end
    end else begin
      queue_result(rbrm_pkg::ST_OK, rd_ptr, n, 0, 0, 0, 0, 0, 1);
    end
  endfunction

  function automatic void step_pointers(logic [2:0] fn, logic [16:0] cnt, logic [15:0] off);
    longint s;
    longint e;
    longint n;
    longint coff;
    longint c;
    longint at;
    longint first;
    longint second;
    int     made;
    s = ring_lo();
    e = ring_hi();
    n = cnt;
    coff = off;
    case (fn)
      rbrm_pkg::FN_RESERVE_ANY: begin
        if (wr_ptr < rd_ptr) begin
          queue_result(rbrm_pkg::ST_OK, wr_ptr, rd_ptr - wr_ptr, 0, 0, 0, 0, 0, 1);
        end else if (wr_ptr == rd_ptr && !ring_empty) begin
          queue_result(rbrm_pkg::ST_NO_SPACE, 0, 0, 0, 0, 0, 0, 0, 1);
        end else begin
          data_mark = e;
          queue_result(rbrm_pkg::ST_OK, wr_ptr, e - wr_ptr, 0, 0, 0, 0, 0, 1);
        end
      end
      rbrm_pkg::FN_RESERVE_N: begin
        if (wr_ptr < rd_ptr) begin
          if (rd_ptr - wr_ptr < n) begin
            queue_result(rbrm_pkg::ST_NO_SPACE, 0, 0, 0, 0, 0, 0, 0, 1);
          end else begin
            queue_result(rbrm_pkg::ST_OK, wr_ptr, n, 0, 0, 0, 0, 0, 1);
          end
        end else if (wr_ptr == rd_ptr && !ring_empty) begin
          queue_result(rbrm_pkg::ST_NO_SPACE, 0, 0, 0, 0, 0, 0, 0, 1);
        end else if (e - wr_ptr >= n) begin
          queue_result(rbrm_pkg::ST_OK, wr_ptr, n, 0, 0, 0, 0, 0, 1);
        end else if (rd_ptr - s >= n) begin
          data_mark = wr_ptr;
          wr_ptr = s;
          queue_result(rbrm_pkg::ST_OK, s, n, 0, 0, 0, 0, 0, 1);
        end else begin
          queue_result(rbrm_pkg::ST_NO_SPACE, 0, 0, 0, 0, 0, 0, 0, 1);
        end
      end
      rbrm_pkg::FN_COMMIT: begin
        if (coff < s || coff >= e) begin
          queue_result(rbrm_pkg::ST_BAD_OFFSET, 0, 0, 0, 0, 0, 0, 0, 1);
        end else begin
          wr_ptr = wr_ptr + n;
          if (wr_ptr > e) wr_ptr = e;
          if (wr_ptr >= e && rd_ptr > s) wr_ptr = s;
          if (n > 0) ring_empty = 1'b0;
          queue_result(rbrm_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0, 1);
        end
      end
      rbrm_pkg::FN_PEEK: begin
        if (n > fill_bytes()) queue_result(rbrm_pkg::ST_NO_SPACE, 0, 0, 0, 0, 0, 0, 0, 1);
        else linear_fetch(n);
      end
      rbrm_pkg::FN_READ: begin
        if (n > cfg_max_read) begin
          queue_result(rbrm_pkg::ST_TOO_LARGE, 0, 0, 0, 0, 0, 0, 0, 1);
        end else if (n > fill_bytes()) begin
          queue_result(rbrm_pkg::ST_NO_SPACE, 0, 0, 0, 0, 0, 0, 0, 1);
        end else begin
          linear_fetch(n);
        end
      end
      rbrm_pkg::FN_RELEASE: begin
        c = fill_bytes();
        if (n < c) c = n;
        if (c > 0) begin
          rd_ptr = sat17(rd_ptr + c);
          ring_empty = (rd_ptr == wr_ptr);
        end
        queue_result(rbrm_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0, 1);
      end
      rbrm_pkg::FN_WRITE: begin
        at = wr_ptr;
        if (room_bytes() < n) begin
          queue_result(rbrm_pkg::ST_NO_SPACE, 0, 0, 0, 0, 0, 0, 0, 1);
        end else begin
          if (n > 0) ring_empty = 1'b0;
          if (wr_ptr + n >= e) begin
            first = e - wr_ptr;
            if (first < 0) first = 0;
            if (first > n) first = n;
            second = n - first;
            data_mark = e;
            wr_ptr = sat17(s + second);
            made = 0;
            if (first > 0) begin
              queue_result(rbrm_pkg::ST_OK, at, n, 1, 1, 0, at, first, second == 0);
              made++;
            end
            if (second > 0) begin
              queue_result(rbrm_pkg::ST_OK, at, n, 1, 1, first, s, second, 1);
              made++;
            end
            if (made == 0) queue_result(rbrm_pkg::ST_OK, at, n, 0, 0, 0, 0, 0, 1);
          end else begin
            wr_ptr = sat17(wr_ptr + n);
            if (n > 0) queue_result(rbrm_pkg::ST_OK, at, n, 1, 1, 0, at, n, 1);
            else queue_result(rbrm_pkg::ST_OK, at, n, 0, 0, 0, 0, 0, 1);
          end
        end
      end
      default: queue_result(rbrm_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0, 1);
    endcase
  endfunction

  function automatic void add_pin(logic [2:0] fn, logic [16:0] cnt, logic [15:0] off,
                                  bit pinned, logic [1:0] st, logic [15:0] roff,
                                  logic [16:0] rlen, logic [16:0] rd, logic [16:0] wr);
    step_row_t row;
    row.is_cfg = 1'b0;
    row.idx = '0;
    row.val = '0;
    row.fn = fn;
    row.cnt = cnt;
    row.off = off;
    row.pinned = pinned;
    row.fixed = '0;
    row.fixed.status = st;
    row.fixed.region_offset = roff;
    row.fixed.region_len = rlen;
    row.fixed.bytes_readable = rd;
    row.fixed.bytes_writable = wr;
    row.fixed.last = 1'b1;
    steps.push_back(row);
  endfunction

  function automatic void add_cmd(logic [2:0] fn, logic [16:0] cnt, logic [15:0] off);
    add_pin(fn, cnt, off, 1'b0, rbrm_pkg::ST_OK, '0, '0, '0, '0);
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [16:0] val);
    step_row_t row;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    row.fn = '0;
    row.cnt = '0;
    row.off = '0;
    row.pinned = 1'b0;
    row.fixed = '0;
    steps.push_back(row);
  endfunction

  function automatic logic [16:0] pick_count(longint hi);
    longint h;
    h = (hi > 65536) ? 65536 : ((hi < 0) ? 0 : hi);
    if ($urandom_range(0, 3) == 0) return 17'(h);
    return 17'($urandom_range(0, int'(h)));
  endfunction

  task automatic send_cmd(logic [2:0] fn, logic [16:0] cnt, logic [15:0] off, bit pinned,
                          rbrm_pkg::result_t fixed);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, off, cnt};
    s_tuser <= fn;
    do @(posedge clk); while (!s_tready);
    step_pointers(fn, cnt, off);
    if (pinned) region_results[region_results.size() - 1] = fixed;
    sent++;
    @(negedge clk);
  endtask

  // Settings change only with the block drained.
  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    s_tvalid <= 1'b0;
    while (region_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == rbrm_pkg::REG_START_POS) begin
      cfg_start = val & 17'h0FFFF;
      reset_pointers();
    end else if (idx == rbrm_pkg::REG_END_POS) begin
      cfg_end = val;
      reset_pointers();
    end else if (idx == rbrm_pkg::REG_MAX_READ) begin
      cfg_max_read = val;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_en && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    rbrm_pkg::result_t got;
    rbrm_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tuser;
      got.region_offset = m_tdata[15:0];
      got.region_len = m_tdata[32:16];
      got.copy_valid = m_tdata[33];
      got.copy_from_input = m_tdata[34];
      got.copy_src = m_tdata[50:35];
      got.copy_dst = m_tdata[66:51];
      got.copy_len = m_tdata[83:67];
      got.bytes_readable = m_tdata[100:84];
      got.bytes_writable = m_tdata[117:101];
      got.last = m_tlast;
      if (region_results.size() == 0) begin
        $error("result transaction with no command waiting for it");
        err_count++;
      end else begin
        want = region_results.pop_front();
        check_field("status", 17'(want.status), 17'(got.status));
        check_field("region_offset", 17'(want.region_offset), 17'(got.region_offset));
        check_field("region_len", want.region_len, got.region_len);
        check_field("copy_valid", 17'(want.copy_valid), 17'(got.copy_valid));
        check_field("copy_from_input", 17'(want.copy_from_input),
                    17'(got.copy_from_input));
        check_field("copy_src", 17'(want.copy_src), 17'(got.copy_src));
        check_field("copy_dst", 17'(want.copy_dst), 17'(got.copy_dst));
        check_field("copy_len", want.copy_len, got.copy_len);
        check_field("bytes_readable", want.bytes_readable, got.bytes_readable);
        check_field("bytes_writable", want.bytes_writable, got.bytes_writable);
        check_field("last", 17'(want.last), 17'(got.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [2:0]  fn;
    logic [16:0] cnt;
    logic [15:0] off;
    longint      rd;
    longint      wr;
    longint      st;
    longint      en;
    longint      lim;
    int          r;
    int          phase;
    int          phase_len;

    cfg_start = rbrm_pkg::RST_START_POS;
    cfg_end = rbrm_pkg::RST_END_POS;
    cfg_max_read = rbrm_pkg::RST_MAX_READ;
    reset_pointers();

    add_pin(rbrm_pkg::FN_READ, 17'd4097, 16'd0, 1, rbrm_pkg::ST_TOO_LARGE,
            16'd0, 17'd0, 17'd0, 17'd61440);
    add_pin(rbrm_pkg::FN_PEEK, 17'd1, 16'd0, 1, rbrm_pkg::ST_NO_SPACE,
            16'd0, 17'd0, 17'd0, 17'd61440);
    add_pin(rbrm_pkg::FN_COMMIT, 17'd5, 16'd0, 1, rbrm_pkg::ST_BAD_OFFSET,
            16'd0, 17'd0, 17'd0, 17'd61440);
    add_pin(rbrm_pkg::FN_COMMIT, 17'd0, 16'd65535, 1, rbrm_pkg::ST_OK,
            16'd0, 17'd0, 17'd0, 17'd61440);
    add_pin(rbrm_pkg::FN_RESERVE_ANY, 17'd0, 16'd0, 1, rbrm_pkg::ST_OK,
            16'd4096, 17'd61440, 17'd0, 17'd61440);
    add_pin(FN_UNKNOWN, 17'd65536, 16'd65535, 1, rbrm_pkg::ST_OK,
            16'd0, 17'd0, 17'd0, 17'd61440);
    add_pin(rbrm_pkg::FN_WRITE, 17'd0, 16'd0, 1, rbrm_pkg::ST_OK,
            16'd4096, 17'd0, 17'd0, 17'd61440);
    add_cmd(rbrm_pkg::FN_RESERVE_N, 17'd100, 16'd0);
    add_cmd(rbrm_pkg::FN_COMMIT, 17'd100, 16'd4096);
    add_cmd(rbrm_pkg::FN_RELEASE, 17'd0, 16'd0);
    add_cmd(rbrm_pkg::FN_RELEASE, 17'd200, 16'd0);
    add_cmd(rbrm_pkg::FN_WRITE, 17'd61440, 16'd0);
    add_cmd(rbrm_pkg::FN_RESERVE_ANY, 17'd0, 16'd0);
    add_cmd(rbrm_pkg::FN_READ, 17'd4096, 16'd0);
    add_cmd(rbrm_pkg::FN_PEEK, 17'd65536, 16'd0);
    add_cmd(rbrm_pkg::FN_COMMIT, 17'd65536, 16'd65535);
    add_cfg(rbrm_pkg::REG_MAX_READ, 17'd65536);
    add_cfg(rbrm_pkg::REG_START_POS, 17'd16);
    add_cfg(rbrm_pkg::REG_END_POS, 17'd300);
    add_cmd(rbrm_pkg::FN_WRITE, 17'd250, 16'd0);
    add_cmd(rbrm_pkg::FN_RELEASE, 17'd200, 16'd0);
    add_cmd(rbrm_pkg::FN_WRITE, 17'd34, 16'd0);
    add_cmd(rbrm_pkg::FN_PEEK, 17'd84, 16'd0);
    add_cmd(rbrm_pkg::FN_RELEASE, 17'd70, 16'd0);
    add_cmd(rbrm_pkg::FN_WRITE, 17'd10, 16'd0);
    add_cmd(rbrm_pkg::FN_PEEK, 17'd20, 16'd0);
    add_cmd(rbrm_pkg::FN_READ, 17'd65536, 16'd0);
    add_cmd(rbrm_pkg::FN_RESERVE_N, 17'd5, 16'd0);
    add_cfg(rbrm_pkg::REG_START_POS, 17'd65535);
    add_pin(rbrm_pkg::FN_WRITE, 17'd1, 16'd0, 1, rbrm_pkg::ST_NO_SPACE,
            16'd0, 17'd0, 17'd0, 17'd0);
    add_pin(rbrm_pkg::FN_RESERVE_ANY, 17'd0, 16'd0, 1, rbrm_pkg::ST_OK,
            16'd65535, 17'd0, 17'd0, 17'd0);
    add_cfg(rbrm_pkg::REG_MAX_READ, 17'd0);
    add_pin(rbrm_pkg::FN_READ, 17'd1, 16'd0, 1, rbrm_pkg::ST_TOO_LARGE,
            16'd0, 17'd0, 17'd0, 17'd0);
    add_cmd(rbrm_pkg::FN_READ, 17'd0, 16'd0);
    add_cfg(REG_UNUSED, 17'h1FFFF);
    add_cfg(rbrm_pkg::REG_START_POS, 17'd0);
    add_cfg(rbrm_pkg::REG_END_POS, 17'd1);
    add_cmd(rbrm_pkg::FN_WRITE, 17'd1, 16'd0);
    add_cmd(rbrm_pkg::FN_PEEK, 17'd1, 16'd0);
    add_cmd(rbrm_pkg::FN_RESERVE_N, 17'd1, 16'd0);
    add_cmd(rbrm_pkg::FN_RELEASE, 17'd65536, 16'd0);
    add_cfg(rbrm_pkg::REG_END_POS, 17'd65536);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    gaps_on = 1'b1;
    stall_en = 1'b1;

    foreach (steps[i]) begin
      if (steps[i].is_cfg) write_reg(steps[i].idx, steps[i].val);
      else send_cmd(steps[i].fn, steps[i].cnt, steps[i].off, steps[i].pinned, steps[i].fixed);
    end

    phase = 0;
    while (sent < ITEMS) begin
      phase++;
      case ($urandom_range(0, 5))
        0: begin
          st = rbrm_pkg::RST_START_POS;
          en = rbrm_pkg::RST_END_POS;
        end
        1: begin
          st = 0;
          en = $urandom_range(1, 400);
        end
        2: begin
          st = 65535;
          en = ($urandom_range(0, 1) == 0) ? 65536 : 1;
        end
        default: begin
          st = $urandom_range(1, 600);
          en = st + $urandom_range(1, 1200);
        end
      endcase
      case ($urandom_range(0, 4))
        0: lim = 0;
        1: lim = 65536;
        default: lim = $urandom_range(1, 800);
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(rbrm_pkg::REG_START_POS, 17'(st));
        write_reg(rbrm_pkg::REG_END_POS, 17'(en));
      end else begin
        write_reg(rbrm_pkg::REG_END_POS, 17'(en));
        write_reg(rbrm_pkg::REG_START_POS, 17'(st));
      end
      write_reg(rbrm_pkg::REG_MAX_READ, 17'(lim));
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 17'($urandom_range(0, 131071)));

      gaps_on = ($urandom_range(0, 3) != 0);
      stall_en = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        gaps_on = 1'b0;
        hold_req = 1'b1;
      end
      phase_len = $urandom_range(60, 180);
      repeat (phase_len) begin
        if (sent >= ITEMS) break;
        if (sent >= ITEMS - QUIET_TAIL) begin
          gaps_on = 1'b0;
          stall_en = 1'b0;
        end
        rd = fill_bytes();
        wr = room_bytes();
        off = (wr_ptr >= ring_lo() && wr_ptr < ring_hi()) ? 16'(wr_ptr) : 16'(ring_lo());
        r = $urandom_range(0, 99);
        if (r < 10) begin
          fn = rbrm_pkg::FN_RESERVE_ANY;
          cnt = pick_count(65536);
        end else if (r < 22) begin
          fn = rbrm_pkg::FN_RESERVE_N;
          cnt = pick_count(wr + 2);
        end else if (r < 38) begin
          fn = rbrm_pkg::FN_COMMIT;
          cnt = pick_count(wr + 1);
          if ($urandom_range(0, 9) == 0) off = 16'($urandom);
        end else if (r < 50) begin
          fn = rbrm_pkg::FN_PEEK;
          cnt = pick_count(rd + 1);
        end else if (r < 62) begin
          fn = rbrm_pkg::FN_READ;
          cnt = pick_count(((rd < cfg_max_read) ? rd : cfg_max_read) + 1);
        end else if (r < 78) begin
          fn = rbrm_pkg::FN_RELEASE;
          cnt = pick_count(rd + 3);
        end else if (r < 95) begin
          fn = rbrm_pkg::FN_WRITE;
          cnt = pick_count(wr + 1);
        end else begin
          fn = 3'($urandom_range(0, 7));
          cnt = 17'($urandom_range(0, 65536));
          off = 16'($urandom);
        end
        send_cmd(fn, cnt, off, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (region_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
